// ----- rtl/core/consistent_hash_ring_core_macros.svh -----
// Assertion macros for the consistent hash ring core.
// Included by RTL files that carry concurrent assertions; no other dependencies.
`ifndef CONSISTENT_HASH_RING_CORE_MACROS_SVH
`define CONSISTENT_HASH_RING_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define CHR_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define CHR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define CHR_ASSERT(lbl, clk, rst_n, prop, msg)
`define CHR_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ----- rtl/core/chr_pkg.sv -----
// Shared types and codes for the consistent hash ring core.
// No dependencies; imported by every other file but the assertion macros header.
package chr_pkg;

	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_DELETE = 2'd1;
	localparam logic [1:0] CMD_LOOKUP = 2'd2;

	localparam logic [2:0] STS_OK        = 3'd0;
	localparam logic [2:0] STS_DUP       = 3'd1;
	localparam logic [2:0] STS_NOT_FOUND = 3'd2;
	localparam logic [2:0] STS_FULL      = 3'd3;
	localparam logic [2:0] STS_EMPTY     = 3'd4;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [63:0] key;
		logic [7:0]  server_id;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [7:0]  server_out;
		logic [31:0] hits_out;
	} rsp_t;

	typedef struct packed {
		logic [63:0] key;
		logic [7:0]  server;
	} point_t;

	typedef struct packed {
		logic busy;
		logic done;
	} hit_stat_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_SEARCH,
		S_COMPARE,
		S_INS_CHK,
		S_INS_MOVE,
		S_DEL_CHK,
		S_DEL_MOVE,
		S_LK_READ,
		S_LK_DATA,
		S_MOD,
		S_HIT,
		S_DONE
	} seq_state_t;

	typedef enum logic [1:0] {
		HS_CLEAR,
		HS_IDLE,
		HS_RMW
	} hit_state_t;

endpackage

// ----- rtl/core/chr_stream_if.sv -----
// Valid/ready channel carrying one request or result.
// Depends on chr_pkg for the default payload type.
interface chr_stream_if import chr_pkg::*; #(
	parameter type T = req_t
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/core/chr_ring_store.sv -----
// Point store of the ring: sorted keys with owning servers.
// One write port, one registered read port. Depends on chr_pkg.
module chr_ring_store import chr_pkg::*; #(
	parameter int RING_SIZE = 256,
	parameter int AW = 8
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  point_t        wdata,
	input  logic [AW-1:0] raddr,
	output point_t        rdata
);
	point_t mem [RING_SIZE];
	point_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;
endmodule

// ----- rtl/core/chr_hit_store.sv -----
// Per-server saturating hit counters with a clearing pass after reset.
// Read-modify-write: the counter is read into rd_q on a request and written back in HS_RMW. Depends on chr_pkg.
module chr_hit_store import chr_pkg::*; #(
	parameter int SERVER_COUNT = 256,
	parameter int HW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req,
	input  logic [HW-1:0] idx,
	output hit_stat_t     stat,
	output logic [31:0]   value
);
	logic [31:0] mem [SERVER_COUNT];
	logic [31:0] rd_q;
	logic [HW-1:0] idx_q;
	logic [HW-1:0] clr_q;
	hit_state_t state_q, state_d;
	logic [31:0] inc;

	assign inc = (rd_q == 32'hFFFF_FFFF) ? rd_q : rd_q + 32'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= HS_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == HS_CLEAR) begin
				clr_q <= clr_q + HW'(1);
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			HS_CLEAR: begin
				if (clr_q == HW'(SERVER_COUNT - 1)) begin
					state_d = HS_IDLE;
				end
			end
			HS_IDLE: begin
				if (req) begin
					state_d = HS_RMW;
				end
			end
			HS_RMW: state_d = HS_IDLE;
			default: state_d = HS_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == HS_CLEAR) begin
			mem[clr_q] <= '0;
		end else if (state_q == HS_RMW) begin
			mem[idx_q] <= inc;
		end
		if (state_q == HS_IDLE && req) begin
			idx_q <= idx;
			rd_q  <= mem[idx];
		end
	end

	assign stat.busy = (state_q == HS_CLEAR);
	assign stat.done = (state_q == HS_RMW);
	assign value     = inc;
endmodule

// ----- rtl/core/chr_seq.sv -----
// Sequencer of the ring: binary search, entry shifting, lookup and result register.
// Drives chr_ring_store and chr_hit_store. Depends on chr_pkg, chr_stream_if, macros.
`include "consistent_hash_ring_core_macros.svh"
module chr_seq import chr_pkg::*; #(
	parameter int RING_SIZE = 256,
	parameter int SERVER_COUNT = 256,
	parameter int AW = 8,
	parameter int OW = 9,
	parameter int HW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	chr_stream_if.sink    req,
	chr_stream_if.source  rsp,
	output logic          ring_we,
	output logic [AW-1:0] ring_waddr,
	output point_t        ring_wdata,
	output logic [AW-1:0] ring_raddr,
	input  point_t        ring_rdata,
	output logic          hit_req,
	output logic [HW-1:0] hit_idx,
	input  hit_stat_t     hit_stat,
	input  logic [31:0]   hit_value
);
	localparam logic       MOD_NEEDED = (SERVER_COUNT < 256);
	localparam logic [7:0] SC8 = 8'(SERVER_COUNT);

	seq_state_t state_q, state_d;
	logic [OW-1:0] occ_q, occ_d;
	logic [OW-1:0] lo_q, lo_d;
	logic [OW-1:0] hi_q, hi_d;
	logic [OW-1:0] ptr_q, ptr_d;
	logic [AW-1:0] mid_q, mid_d;
	logic          found_q, found_d;
	logic [1:0]    cmd_q, cmd_d;
	logic [63:0]   key_q, key_d;
	logic [7:0]    sid_q, sid_d;
	logic [7:0]    mod_q, mod_d;
	rsp_t          pend_q, pend_d;
	rsp_t          rsp_q;
	logic          rsp_valid_q;
	logic          load;

	logic [OW-1:0] mid_w;
	logic          key_lt, key_eq, mod_ge;

	// shared compare unit
	assign key_lt = (ring_rdata.key < key_q);
	assign key_eq = (ring_rdata.key == key_q);
	assign mid_w  = lo_q + ((hi_q - lo_q) >> 1);
	assign mod_ge = MOD_NEEDED && (mod_q >= SC8);
	assign hit_idx = HW'(mod_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			occ_q       <= '0;
			lo_q        <= '0;
			hi_q        <= '0;
			ptr_q       <= '0;
			found_q     <= 1'b0;
			cmd_q       <= CMD_INSERT;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			occ_q   <= occ_d;
			lo_q    <= lo_d;
			hi_q    <= hi_d;
			ptr_q   <= ptr_d;
			found_q <= found_d;
			cmd_q   <= cmd_d;
			if (load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		mid_q  <= mid_d;
		key_q  <= key_d;
		sid_q  <= sid_d;
		mod_q  <= mod_d;
		pend_q <= pend_d;
		if (load) begin
			rsp_q <= pend_q;
		end
	end

	always_comb begin
		state_d    = state_q;
		occ_d      = occ_q;
		lo_d       = lo_q;
		hi_d       = hi_q;
		ptr_d      = ptr_q;
		mid_d      = mid_q;
		found_d    = found_q;
		cmd_d      = cmd_q;
		key_d      = key_q;
		sid_d      = sid_q;
		mod_d      = mod_q;
		pend_d     = pend_q;
		ring_we    = 1'b0;
		ring_waddr = AW'(ptr_q);
		ring_wdata = ring_rdata;
		ring_raddr = AW'(mid_w);
		hit_req    = 1'b0;
		load       = 1'b0;
		case (state_q)
			S_CLEAR: begin
				if (!hit_stat.busy) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (req.valid) begin
					cmd_d   = req.data.cmd;
					key_d   = req.data.key;
					sid_d   = req.data.server_id;
					lo_d    = '0;
					hi_d    = occ_q;
					found_d = 1'b0;
					pend_d  = '0;
					case (req.data.cmd)
						CMD_INSERT, CMD_DELETE: state_d = S_SEARCH;
						CMD_LOOKUP: begin
							if (occ_q == '0) begin
								pend_d.status = STS_EMPTY;
								state_d = S_DONE;
							end else begin
								state_d = S_SEARCH;
							end
						end
						default: state_d = S_DONE;
					endcase
				end
			end
			S_SEARCH: begin
				if (lo_q != hi_q) begin
					mid_d   = AW'(mid_w);
					state_d = S_COMPARE;
				end else begin
					case (cmd_q)
						CMD_INSERT: begin
							if (found_q) begin
								pend_d.status = STS_DUP;
								state_d = S_DONE;
							end else if (occ_q >= OW'(RING_SIZE)) begin
								pend_d.status = STS_FULL;
								state_d = S_DONE;
							end else begin
								ptr_d   = occ_q;
								state_d = S_INS_CHK;
							end
						end
						CMD_DELETE: begin
							if (found_q) begin
								ptr_d   = hi_q;
								state_d = S_DEL_CHK;
							end else begin
								pend_d.status = STS_NOT_FOUND;
								state_d = S_DONE;
							end
						end
						default: state_d = S_LK_READ;
					endcase
				end
			end
			S_COMPARE: begin
				if (key_lt) begin
					lo_d = OW'(mid_q) + OW'(1);
				end else begin
					hi_d    = OW'(mid_q);
					found_d = key_eq;
				end
				state_d = S_SEARCH;
			end
			S_INS_CHK: begin
				if (ptr_q == hi_q) begin
					ring_we    = 1'b1;
					ring_waddr = AW'(hi_q);
					ring_wdata = '{key: key_q, server: sid_q};
					occ_d      = occ_q + OW'(1);
					state_d    = S_DONE;
				end else begin
					ring_raddr = AW'(ptr_q - OW'(1));
					state_d    = S_INS_MOVE;
				end
			end
			S_INS_MOVE: begin
				ring_we = 1'b1;
				ptr_d   = ptr_q - OW'(1);
				state_d = S_INS_CHK;
			end
			S_DEL_CHK: begin
				if (ptr_q + OW'(1) == occ_q) begin
					occ_d   = occ_q - OW'(1);
					state_d = S_DONE;
				end else begin
					ring_raddr = AW'(ptr_q + OW'(1));
					state_d    = S_DEL_MOVE;
				end
			end
			S_DEL_MOVE: begin
				ring_we = 1'b1;
				ptr_d   = ptr_q + OW'(1);
				state_d = S_DEL_CHK;
			end
			S_LK_READ: begin
				// past the largest key: wrap to the smallest point
				ring_raddr = (hi_q >= occ_q) ? '0 : AW'(hi_q);
				state_d    = S_LK_DATA;
			end
			S_LK_DATA: begin
				pend_d.server_out = ring_rdata.server;
				mod_d   = ring_rdata.server;
				state_d = S_MOD;
			end
			S_MOD: begin
				if (mod_ge) begin
					mod_d = mod_q - SC8;
				end else begin
					hit_req = 1'b1;
					state_d = S_HIT;
				end
			end
			S_HIT: begin
				if (hit_stat.done) begin
					pend_d.hits_out = hit_value;
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (!rsp_valid_q || rsp.ready) begin
					load    = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign req.ready = (state_q == S_IDLE);
	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

	`CHR_ASSERT(a_occ_bound, clk, arst_n, occ_q <= OW'(RING_SIZE), "occupancy above ring size")
	`CHR_ASSERT(a_search_window, clk, arst_n, (state_q == S_SEARCH || state_q == S_COMPARE) |-> (lo_q <= hi_q && hi_q <= occ_q), "search window out of order")
	`CHR_ASSERT(a_shift_bound, clk, arst_n, state_q == S_INS_MOVE |-> (ptr_q > hi_q && ptr_q <= occ_q), "insert shift pointer out of range")
	`CHR_ASSERT(a_hit_after_clear, clk, arst_n, hit_req |-> !hit_stat.busy, "hit request during clearing pass")
	`CHR_ASSERT_ALWAYS(a_no_result_in_clear, clk, rsp_valid_q |-> state_q != S_CLEAR, "result before clearing pass ended")
endmodule

// ----- rtl/core/consistent_hash_ring_core.sv -----
// Consistent hash ring core: one request in flight, binary search over the sorted points.
// Accept in S_IDLE; search probes (S_SEARCH read, S_COMPARE) up to ceil(log2(occupancy+1)) times.
// Shifting insert/delete moves one point per CHK/MOVE state pair; lookup reduces server_id modulo
// SERVER_COUNT by repeated subtraction (only below 256 servers); result register held while stalled.
// After arst_n the hit counters are cleared over all SERVER_COUNT entries; no request is taken meanwhile.
// Depends on chr_pkg, chr_stream_if, chr_ring_store, chr_hit_store, chr_seq.
module consistent_hash_ring_core import chr_pkg::*; #(
	parameter int RING_SIZE = 256,
	parameter int SERVER_COUNT = 256
) (
	input  logic         clk,
	input  logic         arst_n,
	chr_stream_if.sink   req,
	chr_stream_if.source rsp
);
	localparam int AW = $clog2(RING_SIZE);
	localparam int OW = $clog2(RING_SIZE + 1);
	localparam int HW = $clog2(SERVER_COUNT);

	logic          ring_we;
	logic [AW-1:0] ring_waddr;
	point_t        ring_wdata;
	logic [AW-1:0] ring_raddr;
	point_t        ring_rdata;
	logic          hit_req;
	logic [HW-1:0] hit_idx;
	hit_stat_t     hit_stat;
	logic [31:0]   hit_value;

	chr_seq #(
		.RING_SIZE(RING_SIZE),
		.SERVER_COUNT(SERVER_COUNT),
		.AW(AW),
		.OW(OW),
		.HW(HW)
	) u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp),
		.ring_we(ring_we),
		.ring_waddr(ring_waddr),
		.ring_wdata(ring_wdata),
		.ring_raddr(ring_raddr),
		.ring_rdata(ring_rdata),
		.hit_req(hit_req),
		.hit_idx(hit_idx),
		.hit_stat(hit_stat),
		.hit_value(hit_value)
	);

	chr_ring_store #(
		.RING_SIZE(RING_SIZE),
		.AW(AW)
	) u_ring (
		.clk(clk),
		.we(ring_we),
		.waddr(ring_waddr),
		.wdata(ring_wdata),
		.raddr(ring_raddr),
		.rdata(ring_rdata)
	);

	chr_hit_store #(
		.SERVER_COUNT(SERVER_COUNT),
		.HW(HW)
	) u_hits (
		.clk(clk),
		.arst_n(arst_n),
		.req(hit_req),
		.idx(hit_idx),
		.stat(hit_stat),
		.value(hit_value)
	);
endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for consistent_hash_ring_core: insert, delete and lookup requests
// over valid/ready channels, checked against a sorted-ring model kept in the bench.
// Depends on chr_pkg, chr_stream_if and the core RTL.
module testbench;
	import chr_pkg::*;

	localparam int RING_SIZE = 256;
	localparam int SERVER_COUNT = 256;
	localparam int unsigned CYCLE_LIMIT = 6_000_000;
	localparam int DRAIN_CYCLES = 700;
	localparam int HOLD_CYCLES = 400;
	localparam int RANDOM_ITEMS = 1140;
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam logic [63:0] KEY_MAX = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] KEY_MID = 64'h8000_0000_0000_0000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	chr_stream_if #(.T(req_t)) req_ch ();
	chr_stream_if #(.T(rsp_t)) rsp_ch ();

	consistent_hash_ring_core #(
		.RING_SIZE(RING_SIZE),
		.SERVER_COUNT(SERVER_COUNT)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	point_t ring_pts[$];
	logic [31:0] hit_tally [SERVER_COUNT];
	rsp_t answers_due[$];
	int err_count = 0;
	int unsigned cycle_count;
	bit src_idle = 1'b0;
	bit snk_idle = 1'b0;
	bit hold_off = 1'b0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80)
			return $urandom_range(1, 3);
		else if (r < 95)
			return $urandom_range(4, 15);
		return $urandom_range(20, 80);
	endfunction

	function automatic logic [63:0] rand_key();
		return {$urandom, $urandom};
	endfunction

	// first point with key not below q; ring_pts.size() if none
	function automatic int unsigned ring_lower(logic [63:0] q);
		int unsigned i;
		i = 0;
		while (i < ring_pts.size() && ring_pts[i].key < q)
			i++;
		return i;
	endfunction

	function automatic bit ring_has(logic [63:0] k);
		int unsigned pos;
		pos = ring_lower(k);
		return pos < ring_pts.size() && ring_pts[pos].key == k;
	endfunction

	function automatic logic [63:0] ring_pick_key();
		if (ring_pts.size() == 0)
			return rand_key();
		return ring_pts[$urandom_range(0, ring_pts.size() - 1)].key;
	endfunction

	function automatic logic [63:0] fresh_key();
		logic [63:0] k;
		k = rand_key();
		while (ring_has(k))
			k = rand_key();
		return k;
	endfunction

	// applies one request to the ring image, returns the response it should produce
	function automatic rsp_t ring_apply(req_t r);
		rsp_t a;
		int unsigned pos;
		int unsigned idx;
		point_t pt;
		a = '0;
		a.status = STS_OK;
		case (r.cmd)
		CMD_INSERT: begin
			pos = ring_lower(r.key);
			if (pos < ring_pts.size() && ring_pts[pos].key == r.key)
				a.status = STS_DUP;
			else if (ring_pts.size() >= RING_SIZE)
				a.status = STS_FULL;
			else begin
				pt.key = r.key;
				pt.server = r.server_id;
				ring_pts.insert(pos, pt);
			end
		end
		CMD_DELETE: begin
			pos = ring_lower(r.key);
			if (pos < ring_pts.size() && ring_pts[pos].key == r.key)
				ring_pts.delete(pos);
			else
				a.status = STS_NOT_FOUND;
		end
		CMD_LOOKUP: begin
			if (ring_pts.size() == 0)
				a.status = STS_EMPTY;
			else begin
				pos = ring_lower(r.key);
				if (pos >= ring_pts.size())
					pos = 0;
				a.server_out = ring_pts[pos].server;
				idx = ring_pts[pos].server % SERVER_COUNT;
				if (hit_tally[idx] != 32'hFFFF_FFFF)
					hit_tally[idx]++;
				a.hits_out = hit_tally[idx];
			end
		end
		default: ;
		endcase
		return a;
	endfunction

	task automatic send_request(input logic [1:0] cmd, input logic [63:0] key,
			input logic [7:0] sid);
		req_t r;
		int gap;
		r.cmd = cmd;
		r.key = key;
		r.server_id = sid;
		if (src_idle && $urandom_range(0, 2) == 0) begin
			gap = pick_gap();
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.data <= r;
		do @(posedge clk); while (!req_ch.ready);
		answers_due.push_back(ring_apply(r));
	endtask

	task automatic check_answer(input rsp_t got);
		rsp_t want;
		if (answers_due.size() == 0) begin
			$error("response with no request pending: status %0d server %0d hits %0d",
				got.status, got.server_out, got.hits_out);
			err_count++;
		end else begin
			want = answers_due.pop_front();
			if (got.status !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, got.status);
				err_count++;
			end
			if (got.server_out !== want.server_out) begin
				$error("server_out: expected %0d, got %0d", want.server_out, got.server_out);
				err_count++;
			end
			if (got.hits_out !== want.hits_out) begin
				$error("hits_out: expected %0d, got %0d", want.hits_out, got.hits_out);
				err_count++;
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready)
			check_answer(rsp_ch.data);
	end

	// response side: random stalls, plus one long hold-off on request
	initial begin
		int gap;
		rsp_ch.ready = 1'b0;
		wait (arst_n);
		forever begin
			if (hold_off) begin
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_off = 1'b0;
			end else if (snk_idle && $urandom_range(0, 3) == 0) begin
				gap = pick_gap();
				rsp_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			@(posedge clk);
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAIL");
		$finish;
	end

	task automatic test_empty_ring();
		send_request(CMD_LOOKUP, KEY_MID, 8'd0);
		send_request(CMD_DELETE, KEY_MID, 8'd0);
		send_request(CMD_UNUSED, 64'd0, 8'd0);
	endtask

	task automatic test_basic_ops();
		send_request(CMD_INSERT, 64'd0, 8'd0);
		send_request(CMD_INSERT, KEY_MAX, 8'd255);
		send_request(CMD_INSERT, KEY_MID, 8'h5A);
		send_request(CMD_INSERT, KEY_MID, 8'hA5);
		send_request(CMD_LOOKUP, 64'd0, 8'd0);
		send_request(CMD_LOOKUP, 64'd1, 8'hFF);
		send_request(CMD_LOOKUP, KEY_MID, 8'd0);
		send_request(CMD_LOOKUP, KEY_MID + 64'd1, 8'd0);
		send_request(CMD_LOOKUP, KEY_MAX, 8'd0);
		send_request(CMD_DELETE, KEY_MAX, 8'd0);
		// nothing above the query: wraps to the smallest point
		send_request(CMD_LOOKUP, KEY_MID + 64'd1, 8'd0);
		send_request(CMD_LOOKUP, KEY_MAX, 8'd0);
		send_request(CMD_DELETE, 64'h1234, 8'd0);
		// counter survives delete of its point
		send_request(CMD_INSERT, KEY_MAX, 8'd255);
		send_request(CMD_LOOKUP, KEY_MAX, 8'd0);
		send_request(CMD_UNUSED, KEY_MAX, 8'd255);
		send_request(CMD_DELETE, 64'd0, 8'd0);
		send_request(CMD_DELETE, KEY_MID, 8'd0);
		send_request(CMD_DELETE, KEY_MAX, 8'd0);
		send_request(CMD_LOOKUP, KEY_MAX, 8'd0);
	endtask

	task automatic test_full_ring();
		int n;
		while (ring_pts.size() < RING_SIZE)
			send_request(CMD_INSERT, fresh_key(), 8'($urandom_range(0, 255)));
		send_request(CMD_INSERT, fresh_key(), 8'd7);
		send_request(CMD_INSERT, ring_pick_key(), 8'd9);
		send_request(CMD_DELETE, fresh_key(), 8'd0);
		for (n = 0; n < 4; n++)
			send_request(CMD_LOOKUP, rand_key(), 8'd0);
		send_request(CMD_DELETE, ring_pick_key(), 8'd0);
		send_request(CMD_INSERT, fresh_key(), 8'd200);
		while (ring_pts.size() > 40)
			send_request(CMD_DELETE, ring_pick_key(), 8'($urandom));
	endtask

	task automatic test_back_pressure();
		int n;
		hold_off = 1'b1;
		for (n = 0; n < 8; n++)
			send_request(n[0] ? CMD_LOOKUP : CMD_INSERT, rand_key(), 8'($urandom));
	endtask

	task automatic test_random(input int count);
		int i;
		int r;
		int v;
		int ins_w;
		int del_w;
		logic [1:0] mode;
		logic [63:0] k;
		for (i = 0; i < count; i++) begin
			if (i % 150 == 0) begin
				mode = (i == 0) ? 2'b00 : (i == 150) ? 2'b11 : 2'($urandom);
				src_idle = mode[0];
				snk_idle = mode[1];
			end
			ins_w = (ring_pts.size() > 120) ? 15 : 35;
			del_w = (ring_pts.size() > 120) ? 35 : 15;
			r = $urandom_range(0, 99);
			if (r < ins_w) begin
				v = $urandom_range(0, 19);
				if (v < 2)
					k = ring_pick_key();
				else if (v == 2)
					k = 64'd0;
				else if (v == 3)
					k = KEY_MAX;
				else
					k = rand_key();
				send_request(CMD_INSERT, k, 8'($urandom));
			end else if (r < ins_w + del_w) begin
				k = ($urandom_range(0, 9) < 7) ? ring_pick_key() : rand_key();
				send_request(CMD_DELETE, k, 8'($urandom));
			end else if (r < 95) begin
				v = $urandom_range(0, 5);
				case (v)
				0: k = rand_key();
				1: k = ring_pick_key();
				2: k = ring_pick_key() + 64'd1;
				3: k = ring_pick_key() - 64'd1;
				4: k = 64'd0;
				default: k = KEY_MAX;
				endcase
				send_request(CMD_LOOKUP, k, 8'($urandom));
			end else
				send_request(CMD_UNUSED, rand_key(), 8'($urandom));
		end
	endtask

	initial begin
		int i;
		req_ch.valid = 1'b0;
		req_ch.data = '0;
		for (i = 0; i < SERVER_COUNT; i++)
			hit_tally[i] = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		src_idle = 1'b1;
		snk_idle = 1'b1;
		test_empty_ring();
		test_basic_ops();
		src_idle = 1'b0;
		snk_idle = 1'b1;
		test_full_ring();
		src_idle = 1'b0;
		snk_idle = 1'b0;
		test_back_pressure();
		test_random(RANDOM_ITEMS);
		req_ch.valid <= 1'b0;

		while (answers_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
